// File: rtl/assert_macros.svh
// Assertion macros shared by the boundary extraction RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, off while reset is low.
`define ASSERT_PROP(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("property violated");

// Check that a condition never holds.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
	`ASSERT_PROP(label, clk, rst_n, !(expr))

`endif

// File: rtl/bbe_pkg.sv
// Shared types, constants and helpers of the boundary extraction block.
package bbe_pkg;

	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 4096;
	localparam int WIDTH_RESET    = 1024;
	localparam int HEIGHT_RESET   = 1024;

	localparam int PIX_W      = 8;
	localparam int IMG_W_BITS = 11;
	localparam int IMG_H_BITS = 13;
	localparam int CFG_DATA_W = 13;
	localparam int CFG_IDX_W  = 2;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [PIX_W-1:0] PIX_BLACK = 8'd0;
	localparam logic [PIX_W-1:0] PIX_WHITE = 8'd255;

	localparam logic REQ_PIXEL = 1'b0;
	localparam logic REQ_FLUSH = 1'b1;

	typedef enum logic [1:0] {
		CLS_ABSENT = 2'd0,
		CLS_ZERO   = 2'd1,
		CLS_WHITE  = 2'd2,
		CLS_OTHER  = 2'd3
	} cls_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 2'd0,
		REG_IMAGE_HEIGHT = 2'd1
	} reg_idx_t;

	// Work item handed from the front end to the window engine.
	typedef struct packed {
		cls_t cls;      // class of the incoming pixel, absent when flushing
		logic wr_en;    // store the class in the line store
		logic bank;     // row parity of the input position
		logic top_ok;   // row two above lies inside the image
		logic mid_ok;   // row one above lies inside the image
		logic col0;     // input sits in the first column
		logic have_out; // this item releases a result
		logic last;     // that result closes the frame
	} op_t;

	localparam int OP_W = $bits(op_t);

	function automatic cls_t classify(input logic [PIX_W-1:0] pix);
		cls_t c;
		if (pix == PIX_BLACK) begin
			c = CLS_ZERO;
		end else if (pix == PIX_WHITE) begin
			c = CLS_WHITE;
		end else begin
			c = CLS_OTHER;
		end
		return c;
	endfunction

endpackage

// File: rtl/binary_boundary_extraction_3x3_top.sv
// Top level of the 3x3 binary boundary extraction block.
//
//  channel  dir  handshake                  payload
//  s_*      in   s_tvalid / s_tready        s_tdata = pixel_in, s_tuser = req_type
//  m_*      out  m_tvalid / m_tready        m_tdata = pixel_out, m_tlast = frame_last
//  cfg_*    in   cfg_valid / cfg_ready      cfg_index = register, cfg_data = value
//
// One item per clock while no register write is offered and the output is taken;
// a releasing beat passes the queue, the read stage and the output register to m_tvalid.
// Each pixel's result is released one row and one pixel after it arrives; flush beats
// drain the last row, and early flush beats are dropped at the front end.
// Reset clears counters, queue and valid flags; line store contents need no clearing.
// A stalled output holds its beat while at least five more input beats are absorbed,
// one in the read stage and four in the queue.
module binary_boundary_extraction_3x3_top #(
	parameter int MAX_WIDTH  = bbe_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = bbe_pkg::MAX_HEIGHT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// input pixel stream
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [bbe_pkg::PIX_W-1:0]      s_tdata,   // [7:0] pixel_in
	input  logic                           s_tuser,   // [0] req_type
	// result stream
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [bbe_pkg::PIX_W-1:0]      m_tdata,   // [7:0] pixel_out
	output logic                           m_tlast,
	// configuration writes
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [bbe_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bbe_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int QW = CW + bbe_pkg::OP_W;

	logic          q_push;
	logic          q_full;
	logic          q_pop;
	logic          q_empty;
	logic [CW-1:0] f_col;
	bbe_pkg::op_t  f_op;
	logic [QW-1:0] q_dout;
	logic [CW-1:0] b_col;
	bbe_pkg::op_t  b_op;

	// Writes are always taken; the front end holds input beats while one is offered.
	assign cfg_ready = 1'b1;

	bbe_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_col     (f_col),
		.q_op      (f_op)
	);

	// Decouple the classifier from the window engine so each can stall alone.
	bbe_queue #(
		.W     (QW),
		.DEPTH (bbe_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    ({f_col, f_op}),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (q_dout),
		.empty  (q_empty)
	);

	assign b_col = q_dout[QW-1:bbe_pkg::OP_W];
	assign b_op  = bbe_pkg::op_t'(q_dout[bbe_pkg::OP_W-1:0]);

	bbe_back #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_pop    (q_pop),
		.q_col    (b_col),
		.q_op     (b_op),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

// File: rtl/bbe_queue.sv
// Small FIFO between the front end and the window engine.
`include "assert_macros.svh"

module bbe_queue #(
	parameter int W     = 16,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] dout,
	output logic         empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	logic [W-1:0]  entry_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [NW-1:0] count_q;

	assign full  = (count_q == NW'(DEPTH));
	assign empty = (count_q == '0);
	assign dout  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + NW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

	`ASSERT_NEVER(a_push_when_full, clk, arst_n, push && full)
	`ASSERT_NEVER(a_pop_when_empty, clk, arst_n, pop && empty)

endmodule

// File: rtl/bbe_front.sv
// Front end: configuration, raster position tracking and item classification.
`include "assert_macros.svh"

module bbe_front #(
	parameter int MAX_WIDTH  = bbe_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = bbe_pkg::MAX_HEIGHT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [bbe_pkg::PIX_W-1:0]       s_tdata,
	input  logic                            s_tuser,
	input  logic                            cfg_valid,
	input  logic [bbe_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bbe_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            q_full,
	output logic                            q_push,
	output logic [$clog2(MAX_WIDTH)-1:0]    q_col,
	output bbe_pkg::op_t                    q_op
);

	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int EWW   = $clog2(MAX_WIDTH + 1);
	localparam int RW    = $clog2(MAX_HEIGHT + 3);
	localparam int W_RST = (bbe_pkg::WIDTH_RESET > MAX_WIDTH) ?
		MAX_WIDTH : bbe_pkg::WIDTH_RESET;
	localparam int H_RST = (bbe_pkg::HEIGHT_RESET > MAX_HEIGHT) ?
		MAX_HEIGHT : bbe_pkg::HEIGHT_RESET;

	logic [EWW-1:0] eff_w_q;
	logic [RW-1:0]  eff_h_q;
	logic [CW-1:0]  col_q;
	logic [RW-1:0]  row_q;

	logic [bbe_pkg::IMG_W_BITS-1:0] wv;
	logic [bbe_pkg::IMG_H_BITS-1:0] hv;
	logic [EWW-1:0] w_clamp;
	logic [RW-1:0]  h_clamp;
	logic [RW-1:0]  h_p1;
	logic [RW-1:0]  h_p2;
	logic           flushing;
	logic           drop;
	logic           col_end;
	logic           col_zero;

	// Hold input beats while a register write is offered, so the two never land together.
	assign s_tready = !q_full && !cfg_valid;

	// Zero acts as one, anything past the maximum acts as the maximum.
	always_comb begin
		wv = cfg_data[bbe_pkg::IMG_W_BITS-1:0];
		hv = cfg_data[bbe_pkg::IMG_H_BITS-1:0];
		if (wv == '0) begin
			w_clamp = EWW'(1);
		end else if (32'(wv) > 32'(MAX_WIDTH)) begin
			w_clamp = EWW'(MAX_WIDTH);
		end else begin
			w_clamp = EWW'(wv);
		end
		if (hv == '0) begin
			h_clamp = RW'(1);
		end else if (32'(hv) > 32'(MAX_HEIGHT)) begin
			h_clamp = RW'(MAX_HEIGHT);
		end else begin
			h_clamp = RW'(hv);
		end
	end

	always_comb begin
		h_p1     = eff_h_q + RW'(1);
		h_p2     = eff_h_q + RW'(2);
		flushing = (row_q >= eff_h_q);
		drop     = (s_tuser == bbe_pkg::REQ_FLUSH) && !flushing;
		col_zero = (col_q == '0);
		col_end  = (EWW'(col_q) == eff_w_q - EWW'(1));

		q_push = s_tvalid && s_tready && !drop;
		q_col  = col_q;

		q_op.cls      = flushing ? bbe_pkg::CLS_ABSENT : bbe_pkg::classify(s_tdata);
		q_op.wr_en    = !flushing;
		q_op.bank     = row_q[0];
		q_op.top_ok   = (row_q >= RW'(2)) && (row_q < h_p2);
		q_op.mid_ok   = (row_q >= RW'(1)) && (row_q < h_p1);
		q_op.col0     = col_zero;
		q_op.have_out = col_zero ? (row_q >= RW'(2)) : (row_q >= RW'(1));
		// Last center leaves with the first column of the second flush row.
		q_op.last     = col_zero && (row_q == h_p1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eff_w_q <= EWW'(W_RST);
			eff_h_q <= RW'(H_RST);
			col_q   <= '0;
			row_q   <= '0;
		end else if (cfg_valid) begin
			case (bbe_pkg::reg_idx_t'(cfg_index))
				bbe_pkg::REG_IMAGE_WIDTH: begin
					eff_w_q <= w_clamp;
					col_q   <= '0;
					row_q   <= '0;
				end
				bbe_pkg::REG_IMAGE_HEIGHT: begin
					eff_h_q <= h_clamp;
					col_q   <= '0;
					row_q   <= '0;
				end
				default: begin
				end
			endcase
		end else if (q_push) begin
			if (q_op.last) begin
				col_q <= '0;
				row_q <= '0;
			end else if (col_end) begin
				col_q <= '0;
				row_q <= row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	`ASSERT_NEVER(a_row_past_flush, clk, arst_n, row_q > h_p1)

endmodule

// File: rtl/bbe_back.sv
// Window engine: line store, 3x3 class window, decision and output register.
`include "assert_macros.svh"

module bbe_back #(
	parameter int MAX_WIDTH = bbe_pkg::MAX_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_empty,
	output logic                         q_pop,
	input  logic [$clog2(MAX_WIDTH)-1:0] q_col,
	input  bbe_pkg::op_t                 q_op,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [bbe_pkg::PIX_W-1:0]    m_tdata,
	output logic                         m_tlast
);

	// One line store bank per row parity.
	bbe_pkg::cls_t mem0 [MAX_WIDTH];
	bbe_pkg::cls_t mem1 [MAX_WIDTH];

	logic          valid_s1;
	bbe_pkg::op_t  op_s1;
	bbe_pkg::cls_t rd0_s1;
	bbe_pkg::cls_t rd1_s1;

	bbe_pkg::cls_t win_q   [3][3];
	bbe_pkg::cls_t shifted [3][3];
	bbe_pkg::cls_t win_nxt [3][3];
	bbe_pkg::cls_t new_col [3];
	bbe_pkg::cls_t sh_col  [3];

	logic                      out_valid_q;
	logic [bbe_pkg::PIX_W-1:0] out_pix_q;
	logic                      out_last_q;

	logic                      out_free;
	logic                      adv;
	logic                      s1_free;
	logic                      all_zero;
	logic [bbe_pkg::PIX_W-1:0] pix;

	assign out_free = !out_valid_q || m_tready;
	assign adv      = valid_s1 && (out_free || !op_s1.have_out);
	assign s1_free  = !valid_s1 || adv;
	assign q_pop    = !q_empty && s1_free;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_pix_q;
	assign m_tlast  = out_last_q;

	// Read both banks before the write of the same item lands.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			rd0_s1 <= mem0[q_col];
			rd1_s1 <= mem1[q_col];
			if (q_op.wr_en && !q_op.bank) begin
				mem0[q_col] <= q_op.cls;
			end
			if (q_op.wr_en && q_op.bank) begin
				mem1[q_col] <= q_op.cls;
			end
		end
	end

	always_comb begin
		new_col[0] = op_s1.top_ok ? (op_s1.bank ? rd1_s1 : rd0_s1) : bbe_pkg::CLS_ABSENT;
		new_col[1] = op_s1.mid_ok ? (op_s1.bank ? rd0_s1 : rd1_s1) : bbe_pkg::CLS_ABSENT;
		new_col[2] = op_s1.cls;
		for (int r = 0; r < 3; r++) begin
			sh_col[r]        = op_s1.col0 ? bbe_pkg::CLS_ABSENT : new_col[r];
			shifted[r][0]    = win_q[r][1];
			shifted[r][1]    = win_q[r][2];
			shifted[r][2]    = sh_col[r];
			win_nxt[r][0]    = op_s1.col0 ? bbe_pkg::CLS_ABSENT : shifted[r][0];
			win_nxt[r][1]    = op_s1.col0 ? bbe_pkg::CLS_ABSENT : shifted[r][1];
			win_nxt[r][2]    = new_col[r];
		end
		all_zero = 1'b1;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				if (!(r == 1 && c == 1) && shifted[r][c] != bbe_pkg::CLS_ZERO) begin
					all_zero = 1'b0;
				end
			end
		end
		if (shifted[1][1] == bbe_pkg::CLS_WHITE || all_zero) begin
			pix = bbe_pkg::PIX_WHITE;
		end else begin
			pix = bbe_pkg::PIX_BLACK;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			op_s1 <= q_op;
		end
		if (adv) begin
			win_q <= win_nxt;
		end
		if (adv && op_s1.have_out) begin
			out_pix_q  <= pix;
			out_last_q <= op_s1.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv && op_s1.have_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`ASSERT_NEVER(a_no_overwrite, clk, arst_n, adv && op_s1.have_out && out_valid_q && !m_tready)
	`ASSERT_PROP(a_result_shown, clk, arst_n, adv && op_s1.have_out |=> m_tvalid)

endmodule
